[rtl/dvru_pkg.sv]
// Package for the distance vector route update unit.
// Holds the table sizes, cost limits, item codes and payload structs.
// No dependencies.
`default_nettype none

package dvru_pkg;

   localparam int ID_W = 4;
   localparam int COST_W = 16;
   localparam int ROUTER_COUNT = 1 << ID_W;

   localparam logic [COST_W-1:0] COST_INFINITY = COST_W'(9999);

   localparam logic [1:0] OP_FORWARD = 2'd0;
   localparam logic [1:0] OP_VECTOR  = 2'd1;
   localparam logic [1:0] OP_LINK    = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [ID_W-1:0]   source_router;
      logic [ID_W-1:0]   entry_index;
      logic [COST_W-1:0] cost_value;
   } dvru_req_type;

   typedef struct packed {
      logic              deliver_local;
      logic [ID_W-1:0]   next_hop;
      logic              next_hop_valid;
      logic [COST_W-1:0] entry_distance;
      logic              route_changed;
   } dvru_rsp_type;

   // One routing table entry as kept in the table memory.
   typedef struct packed {
      logic [COST_W-1:0] distance;
      logic [ID_W-1:0]   next_hop;
      logic              valid_mark;
   } dvru_entry_type;

   localparam dvru_entry_type RESET_ENTRY = '{
      distance:   COST_INFINITY,
      next_hop:   '0,
      valid_mark: 1'b0
   };

endpackage

`default_nettype wire

[rtl/distance_vector_route_update_unit.sv]
// Top level of the distance vector route update unit.
// Depends on dvru_pkg for sizes, codes and payload structs.
`default_nettype none

// Routing table engine for one router. Each request transaction either loads
// a link cost, applies one element of a neighbor's distance vector (poison a
// dead route through that neighbor, then relax through it), or looks up the
// next hop for a packet. Every request yields exactly one response. The table
// lives in one memory with two synchronous read ports (entry and source
// router) and one write port. A request is read at acceptance, then modified
// and written back from the update stage, so one request per cycle is
// sustained while the response output is not stalled. The response is
// registered when its request leaves the update stage. The result written
// by one request is forwarded to the request behind it. Entries not yet
// written read as unreachable through per-entry flip-flops, so no clearing
// pass runs after reset. Write own_router_id only while idle.

module distance_vector_route_update_unit (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  dvru_pkg::dvru_req_type   req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output dvru_pkg::dvru_rsp_type         rsp_data,
   input  wire                            csr_write_enable,
   input  wire  [dvru_pkg::ID_W-1:0]      csr_write_data
);

   dvru_pkg::dvru_entry_type route_mem [dvru_pkg::ROUTER_COUNT];

   logic [dvru_pkg::ID_W-1:0]         own_id_ff;
   logic                              s1_valid_ff;
   dvru_pkg::dvru_req_type            s1_req_ff;
   dvru_pkg::dvru_entry_type          ent_rd_ff;
   dvru_pkg::dvru_entry_type          src_rd_ff;
   logic [dvru_pkg::ROUTER_COUNT-1:0] init_ff;
   logic                              last_wr_valid_ff;
   logic [dvru_pkg::ID_W-1:0]         last_wr_addr_ff;
   dvru_pkg::dvru_entry_type          last_wr_data_ff;
   logic                              rsp_valid_ff;
   dvru_pkg::dvru_rsp_type            rsp_data_ff;

   logic                              req_accept;
   logic                              s1_advance;
   logic                              wr_en;
   dvru_pkg::dvru_entry_type          ent_cur;
   dvru_pkg::dvru_entry_type          src_cur;
   dvru_pkg::dvru_entry_type          poisoned;
   dvru_pkg::dvru_entry_type          wr_data_in;
   dvru_pkg::dvru_rsp_type            rsp_data_in;
   logic [dvru_pkg::COST_W-1:0]       cost_sat;
   logic [dvru_pkg::COST_W-1:0]       link_dist;
   logic [dvru_pkg::COST_W-1:0]       src_dist;
   logic [dvru_pkg::COST_W:0]         relax_sum;
   logic                              poison_hit;
   logic                              relax_hit;
   logic                              changed;

   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= '0;
      end else if (csr_write_enable) begin
         own_id_ff <= csr_write_data;
      end
   end

   // Table memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem[s1_req_ff.entry_index] <= wr_data_in;
      end
      if (req_accept) begin
         ent_rd_ff <= route_mem[req_data.entry_index];
         src_rd_ff <= route_mem[req_data.source_router];
      end
   end

   // A read issued at the edge of a write returns the old data, so the most
   // recent write is kept and substituted on an address match. Entries that
   // were never written read as the reset value.
   always_comb begin
      if (last_wr_valid_ff && last_wr_addr_ff == s1_req_ff.entry_index) begin
         ent_cur = last_wr_data_ff;
      end else if (init_ff[s1_req_ff.entry_index]) begin
         ent_cur = ent_rd_ff;
      end else begin
         ent_cur = dvru_pkg::RESET_ENTRY;
      end
      if (last_wr_valid_ff && last_wr_addr_ff == s1_req_ff.source_router) begin
         src_cur = last_wr_data_ff;
      end else if (init_ff[s1_req_ff.source_router]) begin
         src_cur = src_rd_ff;
      end else begin
         src_cur = dvru_pkg::RESET_ENTRY;
      end
   end

   always_comb begin
      cost_sat = (s1_req_ff.cost_value > dvru_pkg::COST_INFINITY) ?
                 dvru_pkg::COST_INFINITY : s1_req_ff.cost_value;
      link_dist = (s1_req_ff.entry_index == own_id_ff) ? '0 : cost_sat;

      poison_hit = (cost_sat == dvru_pkg::COST_INFINITY) && ent_cur.valid_mark &&
                   (ent_cur.next_hop == s1_req_ff.source_router);
      poisoned = ent_cur;
      if (poison_hit) begin
         poisoned.distance   = dvru_pkg::COST_INFINITY;
         poisoned.valid_mark = 1'b0;
      end

      // When the vector entry is the sender itself, its distance is the one
      // left after poisoning.
      src_dist = (s1_req_ff.source_router == s1_req_ff.entry_index) ?
                 poisoned.distance : src_cur.distance;
      relax_sum = {1'b0, cost_sat} + {1'b0, src_dist};
      relax_hit = (relax_sum != '0) && ({1'b0, poisoned.distance} > relax_sum);

      wr_data_in = ent_cur;
      changed    = 1'b0;
      wr_en      = 1'b0;
      case (s1_req_ff.op)
         dvru_pkg::OP_LINK: begin
            wr_data_in.distance   = link_dist;
            wr_data_in.next_hop   = s1_req_ff.entry_index;
            wr_data_in.valid_mark = 1'b1;
            changed = (ent_cur.distance != link_dist) ||
                      (ent_cur.next_hop != s1_req_ff.entry_index) ||
                      !ent_cur.valid_mark;
            wr_en = s1_valid_ff && s1_advance;
         end
         dvru_pkg::OP_VECTOR: begin
            wr_data_in = poisoned;
            if (relax_hit) begin
               wr_data_in.distance   = relax_sum[dvru_pkg::COST_W-1:0];
               wr_data_in.next_hop   = s1_req_ff.source_router;
               wr_data_in.valid_mark = 1'b1;
            end
            changed = poison_hit || relax_hit;
            wr_en = s1_valid_ff && s1_advance;
         end
         default: begin
            wr_data_in = ent_cur;
         end
      endcase

      rsp_data_in.deliver_local  = (s1_req_ff.op == dvru_pkg::OP_FORWARD) &&
                                   (s1_req_ff.entry_index == own_id_ff);
      rsp_data_in.next_hop       = wr_data_in.next_hop;
      rsp_data_in.next_hop_valid = wr_data_in.valid_mark;
      rsp_data_in.entry_distance = wr_data_in.distance;
      rsp_data_in.route_changed  = changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         init_ff          <= '0;
         last_wr_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_valid_ff && s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            init_ff[s1_req_ff.entry_index] <= 1'b1;
            last_wr_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
      end
      if (s1_valid_ff && s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (wr_en) begin
         last_wr_addr_ff <= s1_req_ff.entry_index;
         last_wr_data_ff <= wr_data_in;
      end
   end

`ifndef SYNTHESIS
   a_stall_needs_work: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with no transaction in the update stage");

   a_write_on_advance: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (s1_valid_ff && s1_advance))
      else $error("table written by a transaction that did not advance");

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_advance) |=> rsp_valid_ff)
      else $error("finished transaction did not reach the response register");

   a_write_marks_init: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (init_ff[$past(s1_req_ff.entry_index)] && last_wr_valid_ff))
      else $error("written entry not marked as initialized");
`endif

endmodule

`default_nettype wire
